[src/csiu_pkg.sv]
// Package for the CSI-u key parameter parser: byte codes, sizes, item type.
// No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps
`default_nettype none

package csiu_pkg;

    localparam int VALUE_BITS_DEF = 21;   // accumulator width default
    localparam int OUT_W          = 21;   // width of each result field
    localparam int CH_W           = 8;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;

    // Field position within the parameter string, saturating at FLD_REST
    localparam logic [1:0] FLD_KEY  = 2'd0;
    localparam logic [1:0] FLD_MOD  = 2'd1;
    localparam logic [1:0] FLD_REST = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            char_present;
        logic            last;
    } csiu_item_t;

endpackage : csiu_pkg

`default_nettype wire

[src/csiu_if.sv]
// Channel interfaces: parameter bytes in, key reports out.
// Depends on csiu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface csiu_in_if;
    logic                      valid;
    logic                      ready;
    logic [csiu_pkg::CH_W-1:0] ch;
    logic                      char_present;
    logic                      last;

    modport source (output valid, output ch, output char_present, output last,
                    input ready);
    modport sink   (input valid, input ch, input char_present, input last,
                    output ready);
endinterface : csiu_in_if

interface csiu_out_if;
    logic                       valid;
    logic                       ready;
    logic [csiu_pkg::OUT_W-1:0] key_code;
    logic [csiu_pkg::OUT_W-1:0] modifier;
    logic [csiu_pkg::OUT_W-1:0] event_type;

    modport source (output valid, output key_code, output modifier,
                    output event_type, input ready);
    modport sink   (input valid, input key_code, input modifier,
                    input event_type, output ready);
endinterface : csiu_out_if

`default_nettype wire

[src/csiu_in_reg.sv]
// Input register for parameter bytes; one item deep, refills while draining.
// Depends on csiu_pkg and csiu_in_if.
`timescale 1ns / 1ps
`default_nettype none

module csiu_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    csiu_in_if.sink            bytes,
    output csiu_pkg::csiu_item_t item,
    output logic               item_valid,
    input  wire logic          item_ready
);
    import csiu_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    csiu_item_t item_reg;
    logic       take;

    assign bytes.ready = !valid_reg || item_ready;
    assign take        = bytes.valid && bytes.ready;
    assign valid_next  = take || (valid_reg && !item_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.ch           <= bytes.ch;
            item_reg.char_present <= bytes.char_present;
            item_reg.last         <= bytes.last;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule : csiu_in_reg

`default_nettype wire

[src/csiu_parse.sv]
// Parser state, per-byte update and field close, and the result register.
// Depends on csiu_pkg and csiu_out_if.
`timescale 1ns / 1ps
`default_nettype none

module csiu_parse #(
    parameter int VALUE_BITS = csiu_pkg::VALUE_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire csiu_pkg::csiu_item_t item,
    input  wire logic            item_valid,
    output logic                 item_ready,
    csiu_out_if.source           report
);
    import csiu_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int FIT_W = (VB < OUT_W) ? VB : OUT_W;
    localparam logic [VB-1:0] ACC_MAX = '1;

    typedef struct packed {
        logic [VB-1:0] main_acc;
        logic [VB-1:0] sub_acc;
        logic          in_sub;
        logic [1:0]    fld;
        logic [VB-1:0] key_hold;
        logic [VB-1:0] mod_hold;
        logic [VB-1:0] event_hold;
    } parse_st_t;

    localparam parse_st_t ST_RESET = '{
        main_acc:   '0,
        sub_acc:    '0,
        in_sub:     1'b0,
        fld:        FLD_KEY,
        key_hold:   '0,
        mod_hold:   VB'(1),
        event_hold: VB'(1)
    };

    function automatic logic [VB-1:0] acc_digit(input logic [VB-1:0] acc,
                                                input logic [3:0]    d);
        logic [VB+3:0] n;
        begin
            n = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VB+4)'(d);
            acc_digit = (n > {4'b0, ACC_MAX}) ? ACC_MAX : n[VB-1:0];
        end
    endfunction

    function automatic parse_st_t close_field(input parse_st_t s);
        parse_st_t r;
        begin
            r = s;
            if (s.fld == FLD_KEY)
            begin
                r.key_hold = s.main_acc;
            end
            else if (s.fld == FLD_MOD)
            begin
                if (s.main_acc != '0)
                begin
                    r.mod_hold = s.main_acc;
                end
                if (s.in_sub && s.sub_acc != '0)
                begin
                    r.event_hold = s.sub_acc;
                end
            end
            if (s.fld != FLD_REST)
            begin
                r.fld = s.fld + 2'd1;
            end
            r.main_acc = '0;
            r.sub_acc  = '0;
            r.in_sub   = 1'b0;
            close_field = r;
        end
    endfunction

    function automatic logic [OUT_W-1:0] fit_out(input logic [VB-1:0] v);
        logic [OUT_W-1:0] r;
        begin
            r = '0;
            r[FIT_W-1:0] = v[FIT_W-1:0];
            fit_out = r;
        end
    endfunction

    parse_st_t st_reg;
    parse_st_t st_next;
    parse_st_t st_byte;
    parse_st_t st_done;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_W-1:0] key_reg;
    logic [OUT_W-1:0] mod_reg;
    logic [OUT_W-1:0] event_reg;
    logic             out_free;
    logic             advance;
    logic [3:0]       digit;

    // A closing item needs a free result slot; others always move on
    assign out_free   = !out_valid_reg || report.ready;
    assign item_ready = !item.last || out_free;
    assign advance    = item_valid && item_ready;
    assign digit      = 4'(item.ch - CH_ZERO);

    always_comb
    begin
        st_byte = st_reg;
        if (item.char_present)
        begin
            case (item.ch) inside
                [CH_ZERO:CH_NINE]:
                begin
                    if (st_reg.in_sub)
                    begin
                        st_byte.sub_acc = acc_digit(st_reg.sub_acc, digit);
                    end
                    else
                    begin
                        st_byte.main_acc = acc_digit(st_reg.main_acc, digit);
                    end
                end
                CH_COLON:
                begin
                    st_byte.in_sub  = 1'b1;
                    st_byte.sub_acc = '0;
                end
                CH_SEMI:
                begin
                    st_byte = close_field(st_reg);
                end
                default:
                begin
                    st_byte = st_reg;
                end
            endcase
        end
        // implicit close on the final byte
        st_done = close_field(st_byte);
        st_next = st_reg;
        if (advance)
        begin
            st_next = item.last ? ST_RESET : st_byte;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !report.ready;
        if (advance && item.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item.last)
        begin
            key_reg   <= fit_out(st_done.key_hold);
            mod_reg   <= fit_out(st_done.mod_hold);
            event_reg <= fit_out(st_done.event_hold);
        end
    end

    assign report.valid      = out_valid_reg;
    assign report.key_code   = key_reg;
    assign report.modifier   = mod_reg;
    assign report.event_type = event_reg;

endmodule : csiu_parse

`default_nettype wire

[src/csi_u_key_param_parser.sv]
// Top level of the CSI-u key parameter parser.
// Depends on csiu_pkg, csiu_if, csiu_in_reg and csiu_parse.
//
//   port     dir   item contents
//   bytes    in    ch, char_present, last
//   report   out   key_code, modifier, event_type (one per last item)
//
// One item per cycle unless a stalled report holds a last item; each item passes
// the input register and its parse step; a last item writes the report register.
// Reset clears parser state (key 0, modifier 1, event 1) and both valids.
// A stalled report holds a following last item in the input register, and the
// bytes behind it wait; bytes of an open string keep flowing, since only a
// closing item writes the report register.
`timescale 1ns / 1ps
`default_nettype none

module csi_u_key_param_parser #(
    parameter int VALUE_BITS = csiu_pkg::VALUE_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    csiu_in_if.sink    bytes,
    csiu_out_if.source report
);
    import csiu_pkg::*;

    csiu_item_t item;
    logic       item_valid;
    logic       item_ready;

    csiu_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    csiu_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .report     (report)
    );

endmodule : csi_u_key_param_parser

`default_nettype wire
